// File: hdl/wpd_pkg.sv
// Shared types for the WAV PCM deframer: result item and the parser push bundle.
`timescale 1ns / 1ps

package wpd_pkg;

  // One result item as delivered on the output channel
  typedef struct packed {
    logic               item_kind;
    logic signed [15:0] sample;
    logic [2:0]         status;
    logic [15:0]        audio_channels;
    logic [31:0]        rate_hz;
    logic [15:0]        sample_bits;
    logic [31:0]        samples_emitted;
    logic               final_item;
  } item_t;

  // Up to two items per input byte: a sample first, then the status item
  typedef struct packed {
    logic  smp_valid;
    item_t smp_item;
    logic  sts_valid;
    item_t sts_item;
  } push_t;

  // Item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindStatus = 1'b1;

endpackage

// File: hdl/wpd_parse.sv
// Byte-level RIFF/WAVE parser: header check, chunk walk, fmt capture, PCM conversion.
`timescale 1ns / 1ps

module wpd_parse
  import wpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output push_t      push_o
);

  // Phase codes
  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhChdr   = 3'd1;
  localparam logic [2:0] PhFmt    = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhSkip   = 3'd4;
  localparam logic [2:0] PhPad    = 3'd5;
  localparam logic [2:0] PhHalt   = 3'd6;
  localparam logic [2:0] PhSmall  = 3'd7;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StHeader   = 3'd1;
  localparam logic [2:0] StOverrun  = 3'd2;
  localparam logic [2:0] StFmtSmall = 3'd3;
  localparam logic [2:0] StUnsupp   = 3'd4;
  localparam logic [2:0] StNoData   = 3'd5;
  localparam logic [2:0] StOrder    = 3'd6;

  // Chunk tags, first byte in the low lane
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [31:0] FmtMinLen = 32'd16;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic        pad_q, pad_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] depth_q, depth_d;
  logic [15:0] sbytes_q, sbytes_d;
  logic [1:0]  sidx_q, sidx_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] total_q, total_d;

  logic [4:0]  cnt_inc;
  logic [31:0] left_dec;
  logic [1:0]  sidx_inc;
  logic [2:0]  width;
  logic        body_done;
  logic [2:0]  body_ph;
  logic        emit;
  logic [15:0] smp_val;
  logic [2:0]  fin_err;

  function automatic logic fmt_ok(logic [15:0] f, logic [15:0] c, logic [31:0] r,
                                  logic [15:0] d);
    fmt_ok = (f == 16'd1) && (c != 16'd0) && (r != 32'd0) &&
             ((d == 16'd8) || (d == 16'd16) || (d == 16'd24) || (d == 16'd32));
  endfunction

  assign cnt_inc  = cnt_q + 5'd1;
  assign left_dec = left_q - 32'd1;
  assign sidx_inc = sidx_q + 2'd1;
  assign width    = depth_q[5:3];

  // Next state for one accepted byte
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    tag_d       = tag_q;
    len_d       = len_q;
    left_d      = left_q;
    pad_d       = pad_q;
    fmt_d       = fmt_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    depth_d     = depth_q;
    sbytes_d    = sbytes_q;
    sidx_d      = sidx_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    err_d       = err_q;
    total_d     = total_q;
    body_done   = 1'b0;
    body_ph     = phase_q;
    emit        = 1'b0;
    smp_val     = 16'd0;
    fin_err     = err_q;

    unique case (phase_q)
      PhHeader: begin
        tag_d = {data_byte_i, tag_q[31:8]};
        cnt_d = cnt_inc;
        if (cnt_inc == 5'd4 && tag_d != TagRiff) begin
          err_d   = StHeader;
          phase_d = PhHalt;
        end else if (cnt_inc == 5'd12) begin
          if (tag_d != TagWave) begin
            err_d   = StHeader;
            phase_d = PhHalt;
          end else begin
            phase_d = PhChdr;
            cnt_d   = 5'd0;
          end
        end
      end
      PhChdr: begin
        if (cnt_q < 5'd4) begin
          tag_d = {data_byte_i, tag_q[31:8]};
        end else begin
          len_d = {data_byte_i, len_q[31:8]};
        end
        cnt_d = cnt_inc;
        // Full chunk header: open the body
        if (cnt_inc >= 5'd8) begin
          left_d = len_d;
          pad_d  = len_d[0];
          cnt_d  = 5'd0;
          if (tag_d == TagFmt) begin
            if (data_seen_q) begin
              err_d   = StOrder;
              phase_d = PhHalt;
            end else begin
              phase_d   = (len_d < FmtMinLen) ? PhSmall : PhFmt;
              body_done = (len_d == 32'd0);
              body_ph   = phase_d;
            end
          end else if (tag_d == TagData) begin
            if (data_seen_q || !fmt_seen_q) begin
              err_d   = StOrder;
              phase_d = PhHalt;
            end else if (!fmt_ok(fmt_q, chan_q, rate_q, depth_q)) begin
              err_d   = StUnsupp;
              phase_d = PhHalt;
            end else begin
              data_seen_d = 1'b1;
              sidx_d      = 2'd0;
              phase_d     = PhData;
              body_done   = (len_d == 32'd0);
              body_ph     = PhData;
            end
          end else begin
            phase_d   = PhSkip;
            body_done = (len_d == 32'd0);
            body_ph   = PhSkip;
          end
        end
      end
      PhFmt: begin
        if (cnt_q < 5'd2) begin
          fmt_d = {data_byte_i, fmt_q[15:8]};
        end else if (cnt_q < 5'd4) begin
          chan_d = {data_byte_i, chan_q[15:8]};
        end else if (cnt_q < 5'd8) begin
          rate_d = {data_byte_i, rate_q[31:8]};
        end else if (cnt_q >= 5'd14 && cnt_q < 5'd16) begin
          depth_d = {data_byte_i, depth_q[15:8]};
        end
        if (cnt_q < 5'd16) begin
          cnt_d = cnt_inc;
        end
        left_d    = left_dec;
        body_done = (left_dec == 32'd0);
      end
      PhData: begin
        sbytes_d = {data_byte_i, sbytes_q[15:8]};
        sidx_d   = sidx_inc;
        // Sample complete once the byte index wraps to the sample width
        if (sidx_inc == width[1:0]) begin
          emit    = 1'b1;
          smp_val = (width == 3'd1) ? {{8{data_byte_i[7]}}, data_byte_i} : sbytes_d;
          sidx_d  = 2'd0;
          if (total_q != 32'hFFFF_FFFF) begin
            total_d = total_q + 32'd1;
          end
        end
        left_d    = left_dec;
        body_done = (left_dec == 32'd0);
      end
      PhSkip, PhSmall: begin
        left_d    = left_dec;
        body_done = (left_dec == 32'd0);
      end
      PhPad: begin
        pad_d   = 1'b0;
        cnt_d   = 5'd0;
        phase_d = PhChdr;
      end
      PhHalt: begin
      end
      default: begin
      end
    endcase

    // Close a chunk body: short fmt fails, otherwise go to pad or next header
    if (body_done) begin
      if (body_ph == PhSmall) begin
        err_d   = StFmtSmall;
        phase_d = PhHalt;
      end else begin
        if (body_ph == PhFmt) begin
          fmt_seen_d = 1'b1;
        end
        sidx_d  = 2'd0;
        cnt_d   = 5'd0;
        phase_d = pad_d ? PhPad : PhChdr;
      end
    end

    // Final status code on the last byte
    fin_err = err_d;
    if (err_d == StOk) begin
      if (phase_d == PhFmt || phase_d == PhData || phase_d == PhSkip ||
          phase_d == PhSmall) begin
        fin_err = StOverrun;
      end else if (phase_d == PhHeader) begin
        fin_err = StHeader;
      end else if (!data_seen_d) begin
        fin_err = (fmt_seen_d && fmt_ok(fmt_d, chan_d, rate_d, depth_d)) ? StNoData
                                                                        : StUnsupp;
      end
    end
  end

  // Result items for this byte
  always_comb begin
    push_o.smp_valid                = accept_i && emit;
    push_o.smp_item.item_kind       = KindSample;
    push_o.smp_item.sample          = smp_val;
    push_o.smp_item.status          = err_d;
    push_o.smp_item.audio_channels  = chan_d;
    push_o.smp_item.rate_hz         = rate_d;
    push_o.smp_item.sample_bits     = depth_d;
    push_o.smp_item.samples_emitted = total_d;
    push_o.smp_item.final_item      = 1'b0;

    push_o.sts_valid                = accept_i && last_byte_i;
    push_o.sts_item.item_kind       = KindStatus;
    push_o.sts_item.sample          = 16'sd0;
    push_o.sts_item.status          = fin_err;
    push_o.sts_item.audio_channels  = chan_d;
    push_o.sts_item.rate_hz         = rate_d;
    push_o.sts_item.sample_bits     = depth_d;
    push_o.sts_item.samples_emitted = total_d;
    push_o.sts_item.final_item      = 1'b1;
  end

  // Parser state; the last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      cnt_q       <= 5'd0;
      tag_q       <= 32'd0;
      len_q       <= 32'd0;
      left_q      <= 32'd0;
      pad_q       <= 1'b0;
      fmt_q       <= 16'd0;
      chan_q      <= 16'd0;
      rate_q      <= 32'd0;
      depth_q     <= 16'd0;
      sbytes_q    <= 16'd0;
      sidx_q      <= 2'd0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      err_q       <= StOk;
      total_q     <= 32'd0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q     <= PhHeader;
        cnt_q       <= 5'd0;
        tag_q       <= 32'd0;
        len_q       <= 32'd0;
        left_q      <= 32'd0;
        pad_q       <= 1'b0;
        fmt_q       <= 16'd0;
        chan_q      <= 16'd0;
        rate_q      <= 32'd0;
        depth_q     <= 16'd0;
        sbytes_q    <= 16'd0;
        sidx_q      <= 2'd0;
        fmt_seen_q  <= 1'b0;
        data_seen_q <= 1'b0;
        err_q       <= StOk;
        total_q     <= 32'd0;
      end else begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        tag_q       <= tag_d;
        len_q       <= len_d;
        left_q      <= left_d;
        pad_q       <= pad_d;
        fmt_q       <= fmt_d;
        chan_q      <= chan_d;
        rate_q      <= rate_d;
        depth_q     <= depth_d;
        sbytes_q    <= sbytes_d;
        sidx_q      <= sidx_d;
        fmt_seen_q  <= fmt_seen_d;
        data_seen_q <= data_seen_d;
        err_q       <= err_d;
        total_q     <= total_d;
      end
    end
  end

endmodule

// File: hdl/wpd_ofifo.sv
// Four-entry result queue taking up to two items per cycle, one out per cycle.
`timescale 1ns / 1ps

module wpd_ofifo
  import wpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  item_t      mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] n_push;
  logic [1:0] wr_next;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_item_o  = mem_q[rd_q];
  // Room for the worst case of two items from one byte
  assign space_o     = (cnt_q <= 3'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = {1'b0, push_i.smp_valid} + {1'b0, push_i.sts_valid};
  assign wr_next     = wr_q + 2'd1;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q + n_push;
    rd_d  = pop ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the sample first, the status item behind it
  always_ff @(posedge clk_i) begin
    if (push_i.smp_valid) begin
      mem_q[wr_q] <= push_i.smp_item;
      if (push_i.sts_valid) begin
        mem_q[wr_next] <= push_i.sts_item;
      end
    end else if (push_i.sts_valid) begin
      mem_q[wr_q] <= push_i.sts_item;
    end
  end

endmodule

// File: hdl/wav_pcm_deframer_to_s16_top.sv
// Top level of the WAV PCM deframer: byte input channel, converted item output channel.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o) carries the file one byte per item,
//   with last_byte_i high on the final byte of the file.
//   Output channel (out_valid_o/out_ready_i) carries sample items as each
//   sample completes, and one status item (final_item_o high) after the
//   last byte, holding the end code and the fmt values of the run.
//   Throughput: one byte per cycle while in_ready_o is high; each byte passes
//   the combinational parser and lands in a four-entry result queue.
//   An item is written into the queue when the byte that caused it is
//   accepted, and is presented on the output once it reaches the queue head.
//   A byte with a sample and the last-byte mark yields two items; the queue
//   takes both in the same cycle.
//   Stall: when the receiver holds out_ready_i low the queue fills, and
//   in_ready_o drops while fewer than two entries are free.
//   Reset: the parser returns to the header phase with all fields zero and
//   the queue empties. After each status item the parser restarts the same
//   way for the next file.
module wav_pcm_deframer_to_s16_top
  import wpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               item_kind_o,
  output logic signed [15:0] sample_o,
  output logic [2:0]         status_o,
  output logic [15:0]        audio_channels_o,
  output logic [31:0]        rate_hz_o,
  output logic [15:0]        sample_bits_o,
  output logic [31:0]        samples_emitted_o,
  output logic               final_item_o
);

  push_t push;
  item_t head;
  logic  space;
  logic  accept;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  wpd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  wpd_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (head)
  );

  // Unpack the head item onto the ports
  assign item_kind_o       = head.item_kind;
  assign sample_o          = head.sample;
  assign status_o          = head.status;
  assign audio_channels_o  = head.audio_channels;
  assign rate_hz_o         = head.rate_hz;
  assign sample_bits_o     = head.sample_bits;
  assign samples_emitted_o = head.samples_emitted;
  assign final_item_o      = head.final_item;

endmodule

// File: tb/wav_pcm_deframer_to_s16_top_tb.sv
// Self-checking testbench for the WAV PCM deframer: streams WAV files in and checks each item.
`timescale 1ns / 1ps

module wav_pcm_deframer_to_s16_top_tb;
  import wpd_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 12;
  localparam int TargetBytes = 900;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 300;

  // Chunk tags as they build up little-endian in a 32-bit shift register
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [15:0] FmtPcm  = 16'd1;

  // End codes carried in the status field
  localparam logic [2:0] EndOk          = 3'd0;
  localparam logic [2:0] EndBadHeader   = 3'd1;
  localparam logic [2:0] EndOverrun     = 3'd2;
  localparam logic [2:0] EndFmtSmall    = 3'd3;
  localparam logic [2:0] EndUnsupported = 3'd4;
  localparam logic [2:0] EndNoData      = 3'd5;
  localparam logic [2:0] EndOrder       = 3'd6;

  typedef enum logic [2:0] {
    PhHeader, PhChunkHdr, PhFmt, PhData, PhSkip, PhPad, PhHalt, PhSmall
  } parse_phase_e;

  // Kinds of generated file
  typedef enum int {
    ScnValid, ScnTrunc, ScnNoise, ScnBadTag, ScnSmallFmt, ScnNoData, ScnDataFirst,
    ScnBadFmt, ScnTwoFmt, ScnFmtAfter, ScnTwoData, ScnTailChunk, ScnCount
  } file_scn_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } wav_byte_t;

  logic               clk_i;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i       = 8'h00;
  logic               last_byte_i       = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic               item_kind_o;
  logic signed [15:0] sample_o;
  logic [2:0]         status_o;
  logic [15:0]        audio_channels_o;
  logic [31:0]        rate_hz_o;
  logic [15:0]        sample_bits_o;
  logic [31:0]        samples_emitted_o;
  logic               final_item_o;

  wav_byte_t   wav_bytes_to_send[$];
  logic [7:0]  file_buf[$];
  item_t       predicted_items[$];
  int          bytes_accepted = 0;
  int          total_bytes    = 0;
  int          mismatches     = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        hold_go        = 1'b0;
  logic        recv_hold      = 1'b0;

  // Parser state mirrored by the predictor
  parse_phase_e wav_phase;
  logic [31:0]  hdr_count, tag_shift, len_shift, body_left;
  logic         pad_due, have_fmt, have_data;
  logic [15:0]  fmt_code, fmt_chans, fmt_depth, pcm_shift;
  logic [31:0]  fmt_rate, pcm_total;
  logic [1:0]   pcm_index;
  logic [2:0]   end_code;

  wav_pcm_deframer_to_s16_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .item_kind_o       (item_kind_o),
    .sample_o          (sample_o),
    .status_o          (status_o),
    .audio_channels_o  (audio_channels_o),
    .rate_hz_o         (rate_hz_o),
    .sample_bits_o     (sample_bits_o),
    .samples_emitted_o (samples_emitted_o),
    .final_item_o      (final_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parser();
    wav_phase = PhHeader;
    hdr_count = '0;
    tag_shift = '0;
    len_shift = '0;
    body_left = '0;
    pad_due   = 1'b0;
    have_fmt  = 1'b0;
    have_data = 1'b0;
    fmt_code  = '0;
    fmt_chans = '0;
    fmt_rate  = '0;
    fmt_depth = '0;
    pcm_shift = '0;
    pcm_index = '0;
    end_code  = EndOk;
    pcm_total = '0;
  endfunction

  function automatic void halt_with(input logic [2:0] code);
    end_code  = code;
    wav_phase = PhHalt;
  endfunction

  function automatic logic fmt_usable();
    return fmt_code == FmtPcm && fmt_chans != 0 && fmt_rate != 0 &&
           (fmt_depth == 16'd8 || fmt_depth == 16'd16 ||
            fmt_depth == 16'd24 || fmt_depth == 16'd32);
  endfunction

  function automatic void push_expected(input logic kind, input logic [15:0] smp,
                                        input logic fin);
    item_t it;
    it.item_kind       = kind;
    it.sample          = smp;
    it.status          = end_code;
    it.audio_channels  = fmt_chans;
    it.rate_hz         = fmt_rate;
    it.sample_bits     = fmt_depth;
    it.samples_emitted = pcm_total;
    it.final_item      = fin;
    predicted_items.push_back(it);
  endfunction

  // End of a chunk body: a short fmt chunk turns into an error only here
  function automatic void close_body();
    if (wav_phase == PhSmall) begin
      halt_with(EndFmtSmall);
      return;
    end
    if (wav_phase == PhFmt) have_fmt = 1'b1;
    pcm_index = '0;
    hdr_count = '0;
    wav_phase = pad_due ? PhPad : PhChunkHdr;
  endfunction

  function automatic void open_chunk();
    body_left = len_shift;
    pad_due   = len_shift[0];
    hdr_count = '0;
    if (tag_shift == TagFmt) begin
      if (have_data) begin
        halt_with(EndOrder);
        return;
      end
      wav_phase = (len_shift < 32'd16) ? PhSmall : PhFmt;
    end else if (tag_shift == TagData) begin
      if (have_data || !have_fmt) begin
        halt_with(EndOrder);
        return;
      end
      if (!fmt_usable()) begin
        halt_with(EndUnsupported);
        return;
      end
      have_data = 1'b1;
      pcm_index = '0;
      wav_phase = PhData;
    end else begin
      wav_phase = PhSkip;
    end
    if (body_left == 0) close_body();
  endfunction

  // Advance the parser by one file byte and queue the items it yields
  function automatic void parse_wav_byte(input logic [7:0] b, input logic is_last);
    logic [2:0]  width;
    logic [15:0] smp;
    case (wav_phase)
      PhHeader: begin
        tag_shift = {b, tag_shift[31:8]};
        hdr_count = hdr_count + 1;
        if (hdr_count == 4 && tag_shift != TagRiff) begin
          halt_with(EndBadHeader);
        end else if (hdr_count == 12) begin
          if (tag_shift != TagWave) begin
            halt_with(EndBadHeader);
          end else begin
            wav_phase = PhChunkHdr;
            hdr_count = '0;
          end
        end
      end
      PhChunkHdr: begin
        if (hdr_count < 4) tag_shift = {b, tag_shift[31:8]};
        else len_shift = {b, len_shift[31:8]};
        hdr_count = hdr_count + 1;
        if (hdr_count >= 8) open_chunk();
      end
      PhFmt: begin
        if (hdr_count < 2) fmt_code = {b, fmt_code[15:8]};
        else if (hdr_count < 4) fmt_chans = {b, fmt_chans[15:8]};
        else if (hdr_count < 8) fmt_rate = {b, fmt_rate[31:8]};
        else if (hdr_count >= 14 && hdr_count < 16) fmt_depth = {b, fmt_depth[15:8]};
        if (hdr_count < 16) hdr_count = hdr_count + 1;
        body_left = body_left - 1;
        if (body_left == 0) close_body();
      end
      PhData: begin
        // keep the two newest bytes: the top of any wider sample
        width     = fmt_depth[5:3];
        pcm_shift = {b, pcm_shift[15:8]};
        pcm_index = pcm_index + 2'd1;
        if (pcm_index == width[1:0]) begin
          smp = (width == 3'd1) ? {{8{pcm_shift[15]}}, pcm_shift[15:8]} : pcm_shift;
          pcm_index = '0;
          if (pcm_total != 32'hFFFF_FFFF) pcm_total = pcm_total + 1;
          push_expected(KindSample, smp, 1'b0);
        end
        body_left = body_left - 1;
        if (body_left == 0) close_body();
      end
      PhSkip, PhSmall: begin
        body_left = body_left - 1;
        if (body_left == 0) close_body();
      end
      PhPad: begin
        pad_due   = 1'b0;
        hdr_count = '0;
        wav_phase = PhChunkHdr;
      end
      default: ;
    endcase
    // Close the file: settle the end code, report it, start over
    if (is_last) begin
      if (end_code == EndOk) begin
        if (wav_phase == PhFmt || wav_phase == PhData || wav_phase == PhSkip ||
            wav_phase == PhSmall)
          halt_with(EndOverrun);
        else if (wav_phase == PhHeader)
          halt_with(EndBadHeader);
        else if (!have_data)
          halt_with((have_fmt && fmt_usable()) ? EndNoData : EndUnsupported);
      end
      push_expected(KindStatus, 16'h0000, 1'b1);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------- file builder

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) file_buf.push_back(value[8*i +: 8]);
  endfunction

  function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] len);
    put_le(tag, 4);
    put_le(len, 4);
    for (int i = 0; i < len; i++) file_buf.push_back(pick_byte());
    if (len[0]) file_buf.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt(input logic [31:0] len, input logic [15:0] code,
                                  input logic [15:0] chans, input logic [31:0] rate,
                                  input logic [15:0] depth);
    if (len < 16) begin
      put_chunk(TagFmt, len);
      return;
    end
    put_le(TagFmt, 4);
    put_le(len, 4);
    put_le({16'h0000, code}, 2);
    put_le({16'h0000, chans}, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'h0000, depth}, 2);
    for (int i = 16; i < len; i++) file_buf.push_back(8'($urandom));
    if (len[0]) file_buf.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] pick_data_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 96) : $urandom_range(0, 24);
  endfunction

  function automatic file_scn_e random_scn();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ScnValid;
    if (r < 55) return ScnTrunc;
    return file_scn_e'($urandom_range(int'(ScnNoise), int'(ScnCount) - 1));
  endfunction

  // Build one file of the given kind and queue its bytes for sending
  function automatic void build_file(input file_scn_e scn);
    logic [15:0] code, chans, depth;
    logic [31:0] rate;
    int          idx, cut;
    file_buf.delete();
    if (scn == ScnNoise) begin
      if ($urandom_range(0, 1) == 1) put_le(TagRiff, 4);
      repeat ($urandom_range(1, 20)) file_buf.push_back(8'($urandom));
    end else begin
      code = FmtPcm;
      case ($urandom_range(0, 3))
        0: depth = 16'd8;
        1: depth = 16'd16;
        2: depth = 16'd24;
        default: depth = 16'd32;
      endcase
      case ($urandom_range(0, 5))
        0: chans = 16'hFFFF;
        1: chans = 16'd2;
        default: chans = 16'd1;
      endcase
      case ($urandom_range(0, 5))
        0: rate = 32'd1;
        1: rate = 32'hFFFF_FFFF;
        default: rate = $urandom;
      endcase
      if (rate == 0) rate = 32'd1;
      // break exactly one fmt field
      if (scn == ScnBadFmt) begin
        case ($urandom_range(0, 3))
          0: begin
            code = 16'($urandom);
            if (code == FmtPcm) code = 16'h0000;
          end
          1: chans = 16'h0000;
          2: rate = 32'h0000_0000;
          default: begin
            depth = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
            if (depth == 16'd8 || depth == 16'd16 || depth == 16'd24 || depth == 16'd32)
              depth = 16'hFFFF;
          end
        endcase
      end
      put_le(TagRiff, 4);
      put_le($urandom, 4);
      put_le(TagWave, 4);
      if (scn == ScnBadTag) begin
        idx = $urandom_range(0, 1) * 8 + $urandom_range(0, 3);
        file_buf[idx] = file_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
      if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5));
      if (scn == ScnDataFirst) put_chunk(TagData, pick_data_len());
      if (scn == ScnTwoFmt) put_fmt(16, 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
      if (scn == ScnSmallFmt)
        put_fmt($urandom_range(0, 15), code, chans, rate, depth);
      else
        put_fmt(($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 5) : 16,
                code, chans, rate, depth);
      if (scn != ScnNoData && scn != ScnDataFirst) put_chunk(TagData, pick_data_len());
      case (scn)
        ScnFmtAfter: put_fmt(16, code, chans, rate, depth);
        ScnTwoData:  put_chunk(TagData, pick_data_len());
        ScnTailChunk: begin
          if ($urandom_range(0, 2) == 0) begin
            // chunk that claims the full length range and is cut off
            put_le($urandom, 4);
            put_le(32'hFFFF_FFFF, 4);
            repeat ($urandom_range(0, 5)) file_buf.push_back(8'($urandom));
          end else begin
            put_chunk($urandom, $urandom_range(0, 9));
          end
        end
        default: ;
      endcase
    end
    cut = file_buf.size();
    if (scn == ScnTrunc) cut = $urandom_range(1, cut - 1);
    for (int i = 0; i < cut; i++)
      wav_bytes_to_send.push_back('{data: file_buf[i], is_last: (i == cut - 1)});
  endfunction

  // ---------------------------------------------------------------- driver / monitor

  // Offer file bytes; predict each one as it is accepted
  always @(posedge clk_i) begin
    wav_byte_t next_byte;
    logic      take;
    if (rst_ni) begin
      take = in_valid_i && in_ready_o;
      if (take) begin
        parse_wav_byte(data_byte_i, last_byte_i);
        bytes_accepted++;
      end
      if (!in_valid_i || take) begin
        if (wav_bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_byte = wav_bytes_to_send.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_byte.data;
          last_byte_i <= next_byte.is_last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each delivered item with the oldest prediction
  always @(posedge clk_i) begin
    item_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.item_kind       = item_kind_o;
        got.sample          = sample_o;
        got.status          = status_o;
        got.audio_channels  = audio_channels_o;
        got.rate_hz         = rate_hz_o;
        got.sample_bits     = sample_bits_o;
        got.samples_emitted = samples_emitted_o;
        got.final_item      = final_item_o;
        if (predicted_items.size() == 0) begin
          $error("item with no prediction waiting: kind %0d sample 0x%0h",
                 got.item_kind, got.sample);
          mismatches++;
        end else begin
          want = predicted_items.pop_front();
          check_field("item_kind", {31'd0, want.item_kind}, {31'd0, got.item_kind});
          check_field("sample", {16'h0000, want.sample}, {16'h0000, got.sample});
          check_field("status", {29'd0, want.status}, {29'd0, got.status});
          check_field("audio_channels", {16'h0000, want.audio_channels},
                      {16'h0000, got.audio_channels});
          check_field("rate_hz", want.rate_hz, got.rate_hz);
          check_field("sample_bits", {16'h0000, want.sample_bits},
                      {16'h0000, got.sample_bits});
          check_field("samples_emitted", want.samples_emitted, got.samples_emitted);
          check_field("final_item", {31'd0, want.final_item}, {31'd0, got.final_item});
        end
      end
      out_ready_i <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the result queue fills and input stalls
  initial begin
    while (!hold_go) @(negedge clk_i);
    recv_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    recv_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $error("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_progress(input int fifth);
    while (bytes_accepted < fifth * total_bytes / 5) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    clear_parser();
    // one file of every kind first, then a random mix
    for (int s = 0; s < int'(ScnCount); s++) build_file(file_scn_e'(s));
    while (wav_bytes_to_send.size() < TargetBytes) build_file(random_scn());
    total_bytes = wav_bytes_to_send.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Step through the idling phases as the files go in
    wait_progress(1);
    send_idle_pct = 49;
    wait_progress(2);
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    wait_progress(3);
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    wait_progress(4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;

    // Drain
    while (wav_bytes_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_items.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
